// File: design/rrpfm_pkg.sv
// Package for the random replacement page frame manager.
// Holds the controller/datapath command and status structs, result codes and constants.
// No dependencies.
`default_nettype none

package rrpfm_pkg;

    // result codes
    typedef enum logic [1:0] {
        KIND_UNMAP   = 2'd0,
        KIND_LOADED  = 2'd1,
        KIND_CLEARED = 2'd2,
        KIND_RANGE   = 2'd3
    } rrpfm_kind_t;

    // operation codes
    localparam logic OP_FAULT = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // register byte addresses
    localparam logic [2:0] REG_FRAME_BASE = 3'd0;

    // field widths
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned TAG_W   = 31;
    localparam int unsigned SLOT_FW = 7;
    localparam int unsigned ROM_W   = 24;
    localparam int unsigned CTX_W   = 26;
    localparam int unsigned BASE_W  = 20;
    localparam int unsigned PAGE_W  = 11;

    // address masks and fixed bits
    localparam logic [TAG_W-1:0] TAG_MASK   = 31'h7FFFE000;
    localparam logic [ROM_W-1:0] ROM_MASK   = 24'hFFE000;
    localparam logic [TAG_W-1:0] EVICT_BASE = 31'h7F000000;
    localparam logic [5:0]       CTX_LOW    = 6'h1F;

    // byte-serial modulo: four byte steps over the 32-bit random word
    localparam int unsigned MOD_STEPS = 4;
    localparam int unsigned STEP_W    = 2;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic emit_clear;
        logic emit_range;
        logic emit_tag;
        logic mod_step;
        logic emit_evict;
        logic emit_load;
    } rrpfm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic op_clear;
        logic page_oob;
        logic slot_busy;
    } rrpfm_status_t;

endpackage

`default_nettype wire

// File: design/rrpfm_ctrl.sv
// Controller state machine of the random replacement page frame manager.
// Sequences decode, modulo steps, slot probe, eviction and load; uses rrpfm_pkg.
`default_nettype none

module rrpfm_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  rrpfm_pkg::rrpfm_status_t    status,
    output rrpfm_pkg::rrpfm_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_PROBE,
        ST_EVICT,
        ST_LOAD
    } state_t;

    state_t                          state_reg;
    logic [rrpfm_pkg::STEP_W-1:0]    step_reg;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    if (status.op_clear || status.page_oob)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_MOD;
                        step_reg  <= rrpfm_pkg::STEP_W'(rrpfm_pkg::MOD_STEPS - 1);
                    end
                end
                ST_MOD:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_PROBE;
                    end
                    else
                    begin
                        step_reg <= step_reg - rrpfm_pkg::STEP_W'(1);
                    end
                end
                ST_PROBE:
                begin
                    state_reg <= status.slot_busy ? ST_EVICT : ST_LOAD;
                end
                ST_EVICT:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // command decode
    always_comb
    begin
        cmd            = '0;
        cmd.load       = (state_reg == ST_IDLE) && start;
        cmd.emit_clear = (state_reg == ST_DECODE) && status.op_clear;
        cmd.emit_range = (state_reg == ST_DECODE) && !status.op_clear && status.page_oob;
        cmd.emit_tag   = (state_reg == ST_DECODE) && !status.op_clear && !status.page_oob;
        cmd.mod_step   = (state_reg == ST_MOD);
        cmd.emit_evict = (state_reg == ST_EVICT);
        cmd.emit_load  = (state_reg == ST_LOAD);
    end

endmodule

`default_nettype wire

// File: design/rrpfm_dp.sv
// Datapath of the random replacement page frame manager: request registers,
// byte-serial modulo unit, slot tables, fault counter and result registers; uses rrpfm_pkg.
`default_nettype none

module rrpfm_dp #(
    parameter int unsigned PAGE_COUNT = 128,
    parameter int unsigned SLOT_COUNT = 90
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  rrpfm_pkg::rrpfm_cmd_t                  cmd,
    output rrpfm_pkg::rrpfm_status_t               status,
    input  wire logic [rrpfm_pkg::BASE_W-1:0]      frame_base_page,
    input  wire logic                              operation,
    input  wire logic [rrpfm_pkg::ADDR_W-1:0]      fault_address,
    input  wire logic [rrpfm_pkg::ADDR_W-1:0]      random_value,
    output logic                                   result_strobe,
    output logic [1:0]                             result_kind,
    output logic [rrpfm_pkg::TAG_W-1:0]            virtual_tag,
    output logic [rrpfm_pkg::SLOT_FW-1:0]          frame_slot,
    output logic [rrpfm_pkg::ROM_W-1:0]            rom_offset,
    output logic [rrpfm_pkg::CTX_W-1:0]            context_word,
    output logic [31:0]                            fault_total,
    output logic                                   last
);

    localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned X_W    = SLOT_W + 8;

    // request registers
    logic                               op_reg;
    logic [rrpfm_pkg::ADDR_W-1:0]       addr_reg;
    logic [rrpfm_pkg::ADDR_W-1:0]       rnd_reg;
    logic [SLOT_W-1:0]                  rem_reg;
    logic [SLOT_W-1:0]                  rem_next;
    logic [31:0]                        counter_reg;

    // slot tables
    logic [SLOT_COUNT-1:0]              slot_free_reg;
    logic [rrpfm_pkg::PAGE_W-1:0]       slot_page_mem [SLOT_COUNT];
    logic [rrpfm_pkg::PAGE_W-1:0]       evict_page_reg;

    // result registers
    logic                               strobe_reg;
    logic [1:0]                         kind_reg;
    logic [rrpfm_pkg::TAG_W-1:0]        tag_reg;
    logic [rrpfm_pkg::SLOT_FW-1:0]      slot_reg;
    logic [rrpfm_pkg::ROM_W-1:0]        rom_reg;
    logic [rrpfm_pkg::CTX_W-1:0]        ctx_reg;
    logic [31:0]                        total_reg;
    logic                               last_reg;

    // derived fields of the captured request
    logic [rrpfm_pkg::PAGE_W-1:0]       page;
    logic [rrpfm_pkg::TAG_W-1:0]        fault_tag;
    logic [rrpfm_pkg::TAG_W-1:0]        evict_tag;
    logic [rrpfm_pkg::ROM_W-1:0]        rom;
    logic [rrpfm_pkg::SLOT_FW-1:0]      slot;
    logic [rrpfm_pkg::BASE_W-1:0]       ctx_page;
    logic [rrpfm_pkg::CTX_W-1:0]        ctx;
    logic [X_W-1:0]                     mod_x;

    assign page      = addr_reg[23:13];
    assign fault_tag = addr_reg[rrpfm_pkg::TAG_W-1:0] & rrpfm_pkg::TAG_MASK;
    assign rom       = addr_reg[rrpfm_pkg::ROM_W-1:0] & rrpfm_pkg::ROM_MASK;
    assign evict_tag = rrpfm_pkg::EVICT_BASE | {7'b0, evict_page_reg, 13'b0};
    assign slot      = rrpfm_pkg::SLOT_FW'(rem_reg);
    assign ctx_page  = frame_base_page + rrpfm_pkg::BASE_W'({slot, 1'b0});
    assign ctx       = {ctx_page, rrpfm_pkg::CTX_LOW};

    // status to the controller
    assign status.op_clear  = (op_reg == rrpfm_pkg::OP_CLEAR);
    assign status.page_oob  = ({1'b0, page} >= 12'(PAGE_COUNT));
    assign status.slot_busy = !slot_free_reg[rem_reg];

    // one modulo step: fold in the next byte, then restoring reduction
    always_comb
    begin
        mod_x = {rem_reg, rnd_reg[31:24]};
        for (int k = 7; k >= 0; k--)
        begin
            if (mod_x >= (X_W'(SLOT_COUNT) << k))
            begin
                mod_x = mod_x - (X_W'(SLOT_COUNT) << k);
            end
        end
        rem_next = mod_x[SLOT_W-1:0];
    end

    // request capture and modulo iteration
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            addr_reg <= fault_address;
            rnd_reg  <= random_value;
            rem_reg  <= '0;
        end
        else if (cmd.mod_step)
        begin
            rnd_reg <= {rnd_reg[23:0], 8'h00};
            rem_reg <= rem_next;
        end
    end

    // fault counter and slot occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            slot_free_reg <= '1;
        end
        else
        begin
            if (cmd.emit_clear)
            begin
                counter_reg <= '0;
            end
            else if (cmd.emit_tag)
            begin
                counter_reg <= counter_reg + 32'd1;
            end
            if (cmd.emit_load)
            begin
                slot_free_reg[rem_reg] <= 1'b0;
            end
        end
    end

    // page held by each slot, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            slot_page_mem[rem_reg] <= page;
        end
        evict_page_reg <= slot_page_mem[rem_reg];
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_clear | cmd.emit_range | cmd.emit_tag
                        | cmd.emit_evict | cmd.emit_load;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_clear | cmd.emit_range | cmd.emit_tag | cmd.emit_evict | cmd.emit_load)
        begin
            tag_reg   <= '0;
            slot_reg  <= '0;
            rom_reg   <= '0;
            ctx_reg   <= '0;
            total_reg <= counter_reg;
            last_reg  <= 1'b1;
            kind_reg  <= rrpfm_pkg::KIND_LOADED;
            if (cmd.emit_clear)
            begin
                kind_reg  <= rrpfm_pkg::KIND_CLEARED;
                total_reg <= '0;
            end
            else if (cmd.emit_range)
            begin
                kind_reg <= rrpfm_pkg::KIND_RANGE;
            end
            else if (cmd.emit_tag)
            begin
                kind_reg  <= rrpfm_pkg::KIND_UNMAP;
                tag_reg   <= fault_tag;
                total_reg <= counter_reg + 32'd1;
                last_reg  <= 1'b0;
            end
            else if (cmd.emit_evict)
            begin
                kind_reg <= rrpfm_pkg::KIND_UNMAP;
                tag_reg  <= evict_tag;
                last_reg <= 1'b0;
            end
            else
            begin
                slot_reg <= slot;
                rom_reg  <= rom;
                ctx_reg  <= ctx;
            end
        end
    end

    assign result_strobe = strobe_reg;
    assign result_kind   = kind_reg;
    assign virtual_tag   = tag_reg;
    assign frame_slot    = slot_reg;
    assign rom_offset    = rom_reg;
    assign context_word  = ctx_reg;
    assign fault_total   = total_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

// File: design/random_replacement_page_frame_manager.sv
// Top level of the random replacement page frame manager.
// Holds the configuration register and joins rrpfm_ctrl and rrpfm_dp; uses rrpfm_pkg.
//
// A request is taken when start is high and busy is low. Each result shows for one
// cycle with result_strobe high and cannot be held off; last marks the final one.
// A clear or an out-of-range page gives its single result through the decode state and
// the result registers, with busy high only in decode. A fault also passes the modulo,
// probe and load states, and an evict state when the chosen slot must be evicted: the
// slot number comes from a byte-serial modulo unit, followed by a registered read of
// the slot table. The unmap result shows in the first modulo cycle; the evict and
// load results come one per cycle at the end. The next request may be taken in the
// cycle that shows the last result.
`default_nettype none

module random_replacement_page_frame_manager #(
    parameter int unsigned PAGE_COUNT = 128,
    parameter int unsigned SLOT_COUNT = 90
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // request
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             operation,
    input  wire logic [rrpfm_pkg::ADDR_W-1:0]     fault_address,
    input  wire logic [rrpfm_pkg::ADDR_W-1:0]     random_value,
    // results
    output logic                                  result_strobe,
    output logic [1:0]                            result_kind,
    output logic [rrpfm_pkg::TAG_W-1:0]           virtual_tag,
    output logic [rrpfm_pkg::SLOT_FW-1:0]         frame_slot,
    output logic [rrpfm_pkg::ROM_W-1:0]           rom_offset,
    output logic [rrpfm_pkg::CTX_W-1:0]           context_word,
    output logic [31:0]                           fault_total,
    output logic                                  last,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic [rrpfm_pkg::BASE_W-1:0]  frame_base_reg;
    rrpfm_pkg::rrpfm_cmd_t         cmd;
    rrpfm_pkg::rrpfm_status_t      status;

    // configuration register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr == rrpfm_pkg::REG_FRAME_BASE))
        begin
            frame_base_reg <= pwdata[rrpfm_pkg::BASE_W-1:0];
        end
    end

    // configuration readback
    assign pready = 1'b1;
    assign prdata = (paddr == rrpfm_pkg::REG_FRAME_BASE) ? 32'(frame_base_reg) : 32'd0;

    rrpfm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    rrpfm_dp #(
        .PAGE_COUNT (PAGE_COUNT),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .frame_base_page (frame_base_reg),
        .operation       (operation),
        .fault_address   (fault_address),
        .random_value    (random_value),
        .result_strobe   (result_strobe),
        .result_kind     (result_kind),
        .virtual_tag     (virtual_tag),
        .frame_slot      (frame_slot),
        .rom_offset      (rom_offset),
        .context_word    (context_word),
        .fault_total     (fault_total),
        .last            (last)
    );

endmodule

`default_nettype wire

// File: design/rrpfm_chk.sv
// Port-level checker for the random replacement page frame manager, with its bind.
// Uses rrpfm_pkg result codes.
`default_nettype none

module rrpfm_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        result_strobe,
    input wire logic [1:0]  result_kind,
    input wire logic [31:0] fault_total,
    input wire logic        last
);

    // an accepted request keeps the block busy on the next cycle
    ap_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after request transfer");

    // nothing is shown in the cycle right after a request transfer
    ap_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !result_strobe)
        else $error("result shown right after request transfer");

    // a cleared counter reads zero and ends its request
    ap_clear: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result_kind == rrpfm_pkg::KIND_CLEARED)
            |-> (fault_total == 32'd0) && last)
        else $error("counter clear result malformed");

    // only unmap results may precede the final result
    ap_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |-> (result_kind == rrpfm_pkg::KIND_UNMAP))
        else $error("non-final result is not an unmap");

endmodule

bind random_replacement_page_frame_manager rrpfm_chk u_rrpfm_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result_kind   (result_kind),
    .fault_total   (fault_total),
    .last          (last)
);

`default_nettype wire

// File: tb/testbench.sv
// Testbench for random_replacement_page_frame_manager: directed and random page faults,
// clears and out-of-range pages, each result checked against a slot table kept here.
// Depends on rrpfm_pkg and the top level in the design folder.

// expected content of one result transfer
typedef struct {
    rrpfm_pkg::rrpfm_kind_t kind;
    logic [30:0]            tag;
    logic [6:0]             slot;
    logic [23:0]            rom;
    logic [25:0]            ctx;
    logic [31:0]            total;
    logic                   last;
} frame_result_t;

// slot table, fault counter and queue of pending results
class frame_table_model;
    localparam int unsigned SLOTS = 90;
    localparam int unsigned PAGES = 128;

    bit [19:0]     base_page;
    bit            slot_free [SLOTS];
    bit [10:0]     slot_page [SLOTS];
    bit [31:0]     faults;
    frame_result_t pending_q [$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   n_faults;
    int unsigned   n_evicts;
    int unsigned   n_range;
    int unsigned   n_clears;

    function new();
        base_page = '0;
        faults = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_free[i] = 1'b1;
            slot_page[i] = '0;
        end
    endfunction

    function void report(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endfunction

    function int unsigned pending();
        return pending_q.size();
    endfunction

    function void push(rrpfm_pkg::rrpfm_kind_t kind, logic [30:0] tag, logic [6:0] slot,
                       logic [23:0] rom, logic [25:0] ctx, logic last);
        frame_result_t r;
        r.kind = kind;
        r.tag = tag;
        r.slot = slot;
        r.rom = rom;
        r.ctx = ctx;
        r.total = faults;
        r.last = last;
        pending_q.push_back(r);
    endfunction

    // work out the results of one accepted request
    function void note_item(logic op, logic [31:0] addr, logic [31:0] rnd);
        logic [23:0]  rom;
        logic [10:0]  page;
        int unsigned  slot;
        logic [19:0]  frame_page;
        rom = addr[23:0] & rrpfm_pkg::ROM_MASK;
        page = addr[23:13];
        if (op == rrpfm_pkg::OP_CLEAR)
        begin
            faults = '0;
            n_clears++;
            push(rrpfm_pkg::KIND_CLEARED, '0, '0, '0, '0, 1'b1);
            return;
        end
        // page beyond the table: no state change, counter not bumped
        if (page >= PAGES)
        begin
            n_range++;
            push(rrpfm_pkg::KIND_RANGE, '0, '0, '0, '0, 1'b1);
            return;
        end
        faults = faults + 1;
        n_faults++;
        push(rrpfm_pkg::KIND_UNMAP, addr[30:0] & rrpfm_pkg::TAG_MASK, '0, '0, '0, 1'b0);
        slot = rnd % SLOTS;
        // occupied victim slot: unmap the page that lived there
        if (!slot_free[slot])
        begin
            n_evicts++;
            push(rrpfm_pkg::KIND_UNMAP,
                 rrpfm_pkg::EVICT_BASE | (31'(slot_page[slot]) << 13), '0, '0, '0, 1'b0);
        end
        frame_page = base_page + 20'(2 * slot);
        slot_free[slot] = 1'b0;
        slot_page[slot] = page;
        push(rrpfm_pkg::KIND_LOADED, '0, 7'(slot), rom, {frame_page, rrpfm_pkg::CTX_LOW},
             1'b1);
    endfunction

    function void check_field(string name, logic [31:0] got, logic [31:0] exp);
        if (got !== exp)
            report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, exp));
    endfunction

    // compare one result transfer with the oldest pending one
    function void check_result(frame_result_t got);
        frame_result_t exp;
        if (pending_q.size() == 0)
        begin
            report($sformatf("result of kind %0d with nothing pending", got.kind));
            return;
        end
        exp = pending_q.pop_front();
        check_field("result_kind", 32'(got.kind), 32'(exp.kind));
        check_field("virtual_tag", 32'(got.tag), 32'(exp.tag));
        check_field("frame_slot", 32'(got.slot), 32'(exp.slot));
        check_field("rom_offset", 32'(got.rom), 32'(exp.rom));
        check_field("context_word", 32'(got.ctx), 32'(exp.ctx));
        check_field("fault_total", got.total, exp.total);
        check_field("last", 32'(got.last), 32'(exp.last));
        checked++;
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        operation;
    logic [31:0] fault_address;
    logic [31:0] random_value;
    logic        result_strobe;
    logic [1:0]  result_kind;
    logic [30:0] virtual_tag;
    logic [6:0]  frame_slot;
    logic [23:0] rom_offset;
    logic [25:0] context_word;
    logic [31:0] fault_total;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_table_model sb;
    bit               burst;

    random_replacement_page_frame_manager i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .fault_address (fault_address),
        .random_value  (random_value),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .virtual_tag   (virtual_tag),
        .frame_slot    (frame_slot),
        .rom_offset    (rom_offset),
        .context_word  (context_word),
        .fault_total   (fault_total),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("random_replacement_page_frame_manager test failed");
        $finish;
    end

    // monitor: check result transfers, then note request transfers
    always @(posedge clk)
    begin
        frame_result_t got;
        if (rst_n)
        begin
            if (result_strobe)
            begin
                got.kind = rrpfm_pkg::rrpfm_kind_t'(result_kind);
                got.tag = virtual_tag;
                got.slot = frame_slot;
                got.rom = rom_offset;
                got.ctx = context_word;
                got.total = fault_total;
                got.last = last;
                sb.check_result(got);
            end
            if (start && !busy)
                sb.note_item(operation, fault_address, random_value);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one request transfer, entered and left at a falling edge
    task automatic send_item(logic op, logic [31:0] addr, logic [31:0] rnd);
        int unsigned gap;
        start <= 1'b1;
        operation <= op;
        fault_address <= addr;
        random_value <= rnd;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // drop start and wait until every result has come
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_cycle(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= rrpfm_pkg::REG_FRAME_BASE;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // write the frame base while idle, then read it back
    task automatic set_base(logic [19:0] value);
        logic [31:0] rdata;
        wait_idle();
        apb_cycle(1'b1, {12'h0, value}, rdata);
        sb.base_page = value;
        apb_cycle(1'b0, 32'h0, rdata);
        if (rdata !== {12'h0, value})
            sb.report($sformatf("frame base reads %0h, expected %0h", rdata, value));
    endtask

    // random request: mostly in-range faults, some clears and pages past the table
    task automatic random_item();
        int unsigned pick;
        int unsigned rsel;
        logic [31:0] addr;
        logic [31:0] rnd;
        pick = $urandom_range(0, 99);
        rsel = $urandom_range(0, 9);
        addr = $urandom;
        if (rsel == 0)
            rnd = $urandom_range(0, 89);
        else if (rsel == 1)
            rnd = 32'hFFFF_FFFF - $urandom_range(0, 200);
        else
            rnd = $urandom;
        if (pick < 6)
            send_item(rrpfm_pkg::OP_CLEAR, addr, rnd);
        else
        begin
            if (pick < 16)
            begin
                if (addr[23:20] == 4'h0)
                    addr[23:20] = 4'($urandom_range(1, 15));
            end
            else
                addr[23:20] = 4'h0;
            send_item(rrpfm_pkg::OP_FAULT, addr, rnd);
        end
    endtask

    initial
    begin
        logic [19:0] bases [5];
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        operation = rrpfm_pkg::OP_FAULT;
        fault_address = '0;
        random_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: top frame base so context words wrap
        set_base(20'hFFFFF);
        send_item(rrpfm_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(rrpfm_pkg::OP_FAULT, 32'h0000_0000, 32'd0);
        send_item(rrpfm_pkg::OP_FAULT, 32'hFFFF_FFFF, 32'd5);
        send_item(rrpfm_pkg::OP_FAULT, 32'hFF0F_FFFF, 32'd89);
        send_item(rrpfm_pkg::OP_FAULT, 32'h0010_0000, 32'd1);
        // slot zero again: evicts page zero, page 127 now resident twice
        send_item(rrpfm_pkg::OP_FAULT, 32'h7F0F_E000, 32'd90);
        send_item(rrpfm_pkg::OP_FAULT, 32'h8000_2000, 32'hFFFF_FFFF);
        // evict the first copy of page 127
        send_item(rrpfm_pkg::OP_FAULT, 32'h0000_1FFF, 32'd89);
        send_item(rrpfm_pkg::OP_FAULT, 32'h000F_FFFF, 32'h8000_0000);
        send_item(rrpfm_pkg::OP_CLEAR, 32'h0000_0000, 32'h0000_0000);
        send_item(rrpfm_pkg::OP_FAULT, 32'h1230_5678, 32'h1234_5678);
        send_item(rrpfm_pkg::OP_FAULT, 32'h0080_0000, 32'd179);

        // directed: base zero
        set_base(20'h00000);
        send_item(rrpfm_pkg::OP_FAULT, 32'h5555_5555 & 32'hFF0F_FFFF, 32'h5555_5555);
        send_item(rrpfm_pkg::OP_FAULT, 32'hAAAA_AAAA & 32'hFF0F_FFFF, 32'hAAAA_AAAA);
        send_item(rrpfm_pkg::OP_FAULT, 32'h000E_0000, 32'd89);
        send_item(rrpfm_pkg::OP_FAULT, 32'h0FF0_0000, 32'd0);

        // random phases over several frame bases
        bases[0] = 20'h00000;
        bases[1] = 20'hFFFFF;
        bases[2] = 20'($urandom);
        bases[3] = 20'h00001;
        bases[4] = 20'($urandom);
        foreach (bases[p])
        begin
            set_base(bases[p]);
            burst = ($urandom_range(0, 3) == 0);
            repeat (100) random_item();
            burst = 1'b0;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d requests: %0d faults, %0d evictions, %0d out of range, %0d clears",
                 sb.n_faults + sb.n_range + sb.n_clears, sb.n_faults,
                 sb.n_evicts, sb.n_range, sb.n_clears);
        $display("%0d result transfers checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("random_replacement_page_frame_manager test passed");
        else
            $display("random_replacement_page_frame_manager test failed");
        $finish;
    end
endmodule
